@@ hdl/lpet_pkg.sv @@
package lpet_pkg;

   localparam int TABLE_SLOTS   = 16;
   localparam int IDX_BITS      = $clog2(TABLE_SLOTS);
   localparam int CNT_BITS      = $clog2(TABLE_SLOTS + 1);
   localparam bit SLOTS_POW2    = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

   localparam int CMD_BITS      = 1;
   localparam int KEY_BITS      = 31;
   localparam int HALF_BITS     = 16;
   localparam int SLOT_OUT_BITS = 4;
   localparam int BIT_CNT_BITS  = $clog2(KEY_BITS + 1);

   localparam logic [CMD_BITS-1:0] CMD_INSERT = 1'b0;
   localparam logic [CMD_BITS-1:0] CMD_SEARCH = 1'b1;

   typedef struct packed {
      logic [KEY_BITS-1:0]  key;
      logic [HALF_BITS-1:0] descriptor;
      logic [HALF_BITS-1:0] send_handle;
      logic [HALF_BITS-1:0] done_handle;
   } slot_entry_type;

   typedef struct packed {
      logic [SLOT_OUT_BITS-1:0] slot;
      logic                     found;
      logic                     table_full;
      logic [HALF_BITS-1:0]     descriptor_out;
      logic [HALF_BITS-1:0]     send_handle_out;
      logic [HALF_BITS-1:0]     done_handle_out;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_MOD    = 5'b00100,
      ST_PROBE  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

@@ hdl/lpet_intf.sv @@
interface lpet_req_intf;
   logic                               valid;
   logic                               ready;
   logic [lpet_pkg::CMD_BITS-1:0]      command;
   logic [lpet_pkg::KEY_BITS-1:0]      key;
   logic [lpet_pkg::HALF_BITS-1:0]     descriptor;
   logic [lpet_pkg::HALF_BITS-1:0]     send_handle;
   logic [lpet_pkg::HALF_BITS-1:0]     done_handle;

   modport source (output valid, command, key, descriptor, send_handle, done_handle,
                   input ready);
   modport sink (input valid, command, key, descriptor, send_handle, done_handle,
                 output ready);
endinterface

interface lpet_rsp_intf;
   logic                               valid;
   logic                               ready;
   logic [lpet_pkg::SLOT_OUT_BITS-1:0] slot;
   logic                               found;
   logic                               table_full;
   logic [lpet_pkg::HALF_BITS-1:0]     descriptor_out;
   logic [lpet_pkg::HALF_BITS-1:0]     send_handle_out;
   logic [lpet_pkg::HALF_BITS-1:0]     done_handle_out;

   modport source (output valid, slot, found, table_full, descriptor_out,
                   send_handle_out, done_handle_out, input ready);
   modport sink (input valid, slot, found, table_full, descriptor_out,
                 send_handle_out, done_handle_out, output ready);
endinterface

@@ hdl/linear_probe_endpoint_table.sv @@
// Linear-probing endpoint table with TABLE_SLOTS slots.
// req_if carries one command per transfer: insert (store key, descriptor and
// two queue handles in the first free slot from key mod TABLE_SLOTS) or search
// (report the first slot in probe order whose key matches). rsp_if returns
// exactly one result per command: slot, found, table_full and the stored values.
// Key zero is never stored or found; it returns an all-zero result.
// One command is in work at a time; req_if.ready is high only while idle.
// The start slot is the low key bits for a power-of-two slot count, and
// otherwise a reciprocal multiply, then a multiply-back and subtract. Probing
// reads the slot memory once per cycle through its single read port, slot by
// slot until a match or until all TABLE_SLOTS slots have missed. The walk holds
// the block: a new command is taken only once the last command's result has
// gone to the output stage.
// After reset the block sweeps every slot to free, one slot per cycle, with
// req_if.ready low.
// A stalled result waits in the output register; the next command is accepted
// meanwhile and its result waits until that register is taken.
module linear_probe_endpoint_table (
   input logic          clock,
   input logic          reset,
   lpet_req_intf.sink   req_if,
   lpet_rsp_intf.source rsp_if
);
   import lpet_pkg::*;

   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(TABLE_SLOTS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(TABLE_SLOTS - 1);
   localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(TABLE_SLOTS - 1);

   state_type             state_ff, state_in;
   logic [IDX_BITS-1:0]   clr_addr_ff, clr_addr_in;
   logic [CMD_BITS-1:0]   cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [HALF_BITS-1:0]  desc_ff, desc_in;
   logic [HALF_BITS-1:0]  send_hdl_ff, send_hdl_in;
   logic [HALF_BITS-1:0]  done_hdl_ff, done_hdl_in;
   logic [IDX_BITS-1:0]   addr_ff, addr_in;
   logic [CNT_BITS-1:0]   issue_cnt_ff, issue_cnt_in;
   logic [CNT_BITS-1:0]   cmp_cnt_ff, cmp_cnt_in;
   logic [IDX_BITS-1:0]   rd_tag_ff, rd_tag_in;
   logic                  rd_valid_ff, rd_valid_in;
   rsp_payload_type       res_ff, res_in;
   rsp_payload_type       rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  mod_start;
   logic                  mod_done;
   logic [IDX_BITS-1:0]   mod_rem;
   logic                  mem_wr_en;
   logic [IDX_BITS-1:0]   mem_wr_addr;
   slot_entry_type        mem_wr_data;
   logic                  mem_rd_en;
   slot_entry_type        mem_rd_data;
   logic                  probe_match;
   logic                  probe_hit;
   logic                  probe_miss;
   logic                  rsp_load;

   lpet_mod_unit u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .key_in (key_in),
      .done   (mod_done),
      .rem    (mod_rem)
   );

   lpet_slot_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data)
   );

   assign req_if.ready = (state_ff == ST_IDLE);

   assign mem_rd_en   = (state_ff == ST_PROBE) && (issue_cnt_ff != CNT_FULL);
   assign probe_match = (mem_rd_data.key == ((cmd_ff == CMD_INSERT) ? '0 : key_ff));
   assign probe_hit   = (state_ff == ST_PROBE) && rd_valid_ff && probe_match;
   assign probe_miss  = (state_ff == ST_PROBE) && rd_valid_ff && !probe_match &&
                        (cmp_cnt_ff == CNT_LAST);

   assign mem_wr_en   = (state_ff == ST_CLEAR) || (probe_hit && (cmd_ff == CMD_INSERT));
   assign mem_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : rd_tag_ff;
   always_comb begin
      mem_wr_data = '0;
      if (state_ff != ST_CLEAR) begin
         mem_wr_data.key         = key_ff;
         mem_wr_data.descriptor  = desc_ff;
         mem_wr_data.send_handle = send_hdl_ff;
         mem_wr_data.done_handle = done_hdl_ff;
      end
   end

   assign rd_valid_in = mem_rd_en;
   assign rd_tag_in   = mem_rd_en ? addr_ff : rd_tag_ff;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      desc_in      = desc_ff;
      send_hdl_in  = send_hdl_ff;
      done_hdl_in  = done_hdl_ff;
      addr_in      = addr_ff;
      issue_cnt_in = issue_cnt_ff;
      cmp_cnt_in   = cmp_cnt_ff;
      res_in       = res_ff;
      mod_start    = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == IDX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd_in      = req_if.command;
            key_in      = req_if.key;
            desc_in     = req_if.descriptor;
            send_hdl_in = req_if.send_handle;
            done_hdl_in = req_if.done_handle;
            if (req_if.valid) begin
               if (req_if.key == '0) begin
                  res_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  mod_start = 1'b1;
                  state_in  = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               addr_in      = mod_rem;
               issue_cnt_in = '0;
               cmp_cnt_in   = '0;
               state_in     = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (mem_rd_en) begin
               addr_in      = (addr_ff == IDX_LAST) ? '0 : addr_ff + 1'b1;
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               cmp_cnt_in = cmp_cnt_ff + 1'b1;
            end
            if (probe_hit) begin
               res_in.slot       = SLOT_OUT_BITS'(rd_tag_ff);
               res_in.found      = 1'b1;
               res_in.table_full = 1'b0;
               if (cmd_ff == CMD_INSERT) begin
                  res_in.descriptor_out  = desc_ff;
                  res_in.send_handle_out = send_hdl_ff;
                  res_in.done_handle_out = done_hdl_ff;
               end else begin
                  res_in.descriptor_out  = mem_rd_data.descriptor;
                  res_in.send_handle_out = mem_rd_data.send_handle;
                  res_in.done_handle_out = mem_rd_data.done_handle;
               end
               state_in = ST_FINISH;
            end else if (probe_miss) begin
               res_in            = '0;
               res_in.table_full = (cmd_ff == CMD_INSERT);
               state_in          = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (rsp_load) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         issue_cnt_ff <= '0;
         cmp_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         issue_cnt_ff <= issue_cnt_in;
         cmp_cnt_ff   <= cmp_cnt_in;
      end
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      desc_ff     <= desc_in;
      send_hdl_ff <= send_hdl_in;
      done_hdl_ff <= done_hdl_in;
      addr_ff     <= addr_in;
      rd_tag_ff   <= rd_tag_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.slot            = rsp_ff.slot;
   assign rsp_if.found           = rsp_ff.found;
   assign rsp_if.table_full      = rsp_ff.table_full;
   assign rsp_if.descriptor_out  = rsp_ff.descriptor_out;
   assign rsp_if.send_handle_out = rsp_ff.send_handle_out;
   assign rsp_if.done_handle_out = rsp_ff.done_handle_out;

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff == ST_MOD) || (state_ff == ST_FINISH))
      else $error("transfer did not start a command");

   a_cmp_behind_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (cmp_cnt_ff <= issue_cnt_ff))
      else $error("compare count passed read count");

   a_found_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.found && rsp_ff.table_full))
      else $error("result both found and full");

   a_write_only_on_insert: assert property (@(posedge clock) disable iff (reset)
      (mem_wr_en && (state_ff != ST_CLEAR)) |-> (cmd_ff == CMD_INSERT) && (key_ff != '0))
      else $error("slot write outside an insert");

endmodule

@@ hdl/lpet_slot_ram.sv @@
module lpet_slot_ram (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [lpet_pkg::IDX_BITS-1:0]  wr_addr,
   input  lpet_pkg::slot_entry_type       wr_data,
   input  logic                           rd_en,
   input  logic [lpet_pkg::IDX_BITS-1:0]  rd_addr,
   output lpet_pkg::slot_entry_type       rd_data
);
   import lpet_pkg::*;

   slot_entry_type mem_ff [TABLE_SLOTS];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lpet_mod_unit.sv @@
module lpet_mod_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lpet_pkg::KEY_BITS-1:0] key_in,
   output logic                          done,
   output logic [lpet_pkg::IDX_BITS-1:0] rem
);
   import lpet_pkg::*;

   localparam int RECIP_BITS  = 32;
   localparam int RECIP_SHIFT = KEY_BITS + IDX_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP =
      RECIP_BITS'((64'd1 << RECIP_SHIFT) / TABLE_SLOTS + 1);
   localparam logic [KEY_BITS-1:0] SLOTS_KEY = KEY_BITS'(TABLE_SLOTS);

   logic                           mul_ff, mul_in;
   logic                           sub_ff, sub_in;
   logic                           done_ff, done_in;
   logic [IDX_BITS-1:0]            rem_ff, rem_in;
   logic [KEY_BITS-1:0]            hold_ff, hold_in;
   logic [KEY_BITS-1:0]            quot_ff, quot_in;
   logic [KEY_BITS+RECIP_BITS-1:0] prod;
   logic [KEY_BITS-1:0]            back;
   logic [KEY_BITS-1:0]            resid;

   assign prod  = {RECIP_BITS'(0), hold_ff} * {KEY_BITS'(0), RECIP};
   assign back  = quot_ff * SLOTS_KEY;
   assign resid = hold_ff - back;

   always_comb begin
      mul_in  = 1'b0;
      sub_in  = mul_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      hold_in = hold_ff;
      quot_in = quot_ff;
      if (start) begin
         if (SLOTS_POW2) begin
            rem_in  = key_in[IDX_BITS-1:0];
            done_in = 1'b1;
         end else begin
            hold_in = key_in;
            mul_in  = 1'b1;
         end
      end
      if (mul_ff) begin
         quot_in = KEY_BITS'(prod >> RECIP_SHIFT);
      end
      if (sub_ff) begin
         rem_in  = resid[IDX_BITS-1:0];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         sub_ff  <= sub_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      hold_ff <= hold_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

@@ dv/tb_top.sv @@
module tb_top;
   import lpet_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam logic [KEY_BITS-1:0] KEY_MAX = '1;
   localparam logic [HALF_BITS-1:0] HALF_MAX = '1;

   logic clock;
   logic reset;

   lpet_req_intf req_if();
   lpet_rsp_intf rsp_if();

   linear_probe_endpoint_table uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   slot_entry_type  endpoint_slots [TABLE_SLOTS];
   rsp_payload_type slot_reports_due [$];
   int              error_count;
   int              idle_cycles;
   int              burst_left;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic rsp_payload_type endpoint_table_apply(input logic [CMD_BITS-1:0] cmd,
                                                            input slot_entry_type item);
      rsp_payload_type r;
      int idx;
      r = '0;
      if (item.key == '0) return r;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         idx = int'((longint'(item.key) + i) % TABLE_SLOTS);
         if ((cmd == CMD_INSERT && endpoint_slots[idx].key == '0) ||
             (cmd == CMD_SEARCH && endpoint_slots[idx].key == item.key)) begin
            if (cmd == CMD_INSERT) endpoint_slots[idx] = item;
            r.slot            = SLOT_OUT_BITS'(idx);
            r.found           = 1'b1;
            r.descriptor_out  = endpoint_slots[idx].descriptor;
            r.send_handle_out = endpoint_slots[idx].send_handle;
            r.done_handle_out = endpoint_slots[idx].done_handle;
            return r;
         end
      end
      r.table_full = (cmd == CMD_INSERT);
      return r;
   endfunction

   function automatic int free_slot_count();
      int n;
      n = 0;
      foreach (endpoint_slots[i]) if (endpoint_slots[i].key == '0) n++;
      return n;
   endfunction

   // cluster half of the keys on a few start slots to force long probe chains
   function automatic logic [KEY_BITS-1:0] random_key();
      logic [KEY_BITS-1:0] k;
      k = KEY_BITS'($urandom);
      if ($urandom_range(0, 1) == 1) k[3:0] = 4'($urandom_range(0, 3));
      return k;
   endfunction

   function automatic logic [KEY_BITS-1:0] pick_search_key();
      logic [KEY_BITS-1:0] k;
      int pick;
      pick = $urandom_range(0, 19);
      k = endpoint_slots[$urandom_range(0, TABLE_SLOTS - 1)].key;
      if (k == '0) k = random_key();
      if (pick >= 17) k = random_key();
      else if (pick >= 15) k = '0;
      else if (pick >= 12) k[$urandom_range(4, KEY_BITS - 1)] ^= 1'b1;
      return k;
   endfunction

   function automatic slot_entry_type make_entry(input logic [KEY_BITS-1:0] k);
      slot_entry_type e;
      e.key         = k;
      e.descriptor  = HALF_BITS'($urandom);
      e.send_handle = HALF_BITS'($urandom);
      e.done_handle = HALF_BITS'($urandom);
      return e;
   endfunction

   task automatic send_op(input logic [CMD_BITS-1:0] cmd, input slot_entry_type item);
      int gap;
      @(negedge clock);
      req_if.command     = cmd;
      req_if.key         = item.key;
      req_if.descriptor  = item.descriptor;
      req_if.send_handle = item.send_handle;
      req_if.done_handle = item.done_handle;
      req_if.valid       = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      slot_reports_due.push_back(endpoint_table_apply(cmd, item));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 7);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            @(negedge clock);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic test_key_zero();
      send_op(CMD_INSERT, '{key: '0, descriptor: HALF_MAX, send_handle: HALF_MAX,
                            done_handle: HALF_MAX});
      send_op(CMD_SEARCH, make_entry('0));
   endtask

   task automatic test_empty_misses();
      send_op(CMD_SEARCH, make_entry(KEY_MAX));
      send_op(CMD_SEARCH, make_entry(KEY_BITS'(1)));
   endtask

   task automatic test_field_extremes();
      send_op(CMD_INSERT, '{key: KEY_MAX, descriptor: HALF_MAX, send_handle: HALF_MAX,
                            done_handle: HALF_MAX});
      send_op(CMD_INSERT, '{key: KEY_BITS'(1), descriptor: '0, send_handle: '0,
                            done_handle: '0});
      send_op(CMD_SEARCH, make_entry(KEY_MAX));
      send_op(CMD_SEARCH, make_entry(KEY_BITS'(1)));
   endtask

   task automatic test_probe_collisions();
      send_op(CMD_INSERT, make_entry(KEY_BITS'('h10)));
      send_op(CMD_INSERT, make_entry(KEY_BITS'('h7FFF_FFF0)));
      send_op(CMD_INSERT, make_entry(KEY_BITS'('h2F)));
      send_op(CMD_INSERT, make_entry(KEY_BITS'(1)));
      send_op(CMD_SEARCH, make_entry(KEY_BITS'(1)));
      send_op(CMD_SEARCH, make_entry(KEY_BITS'('h2F)));
      send_op(CMD_SEARCH, make_entry(KEY_BITS'('h7FFF_FFF0)));
      send_op(CMD_SEARCH, make_entry(KEY_BITS'('h3F)));
   endtask

   task automatic test_fill_to_full();
      while (free_slot_count() > 0) begin
         if ($urandom_range(0, 5) == 0) send_op(CMD_INSERT, make_entry(random_key()));
         else send_op(CMD_SEARCH, make_entry(pick_search_key()));
      end
      send_op(CMD_INSERT, make_entry(KEY_MAX));
      send_op(CMD_INSERT, make_entry('0));
      send_op(CMD_SEARCH, make_entry(KEY_BITS'('h3F)));
   endtask

   task automatic test_random_traffic(input int count);
      logic [CMD_BITS-1:0] cmd;
      logic [KEY_BITS-1:0] k;
      repeat (count) begin
         cmd = ($urandom_range(0, 9) < 3) ? CMD_INSERT : CMD_SEARCH;
         if (cmd == CMD_INSERT) k = ($urandom_range(0, 9) == 0) ? '0 : random_key();
         else k = pick_search_key();
         send_op(cmd, make_entry(k));
      end
   endtask

   initial begin
      int mode;
      rsp_if.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(1, 40)) begin
            @(negedge clock);
            case (mode)
               0: rsp_if.ready = 1'b1;
               1: rsp_if.ready = 1'($urandom_range(0, 1));
               default: rsp_if.ready = 1'b0;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type exp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (slot_reports_due.size() == 0) begin
            $error("result with no pending operation: slot %0d found %0b",
                   rsp_if.slot, rsp_if.found);
            error_count++;
         end else begin
            exp = slot_reports_due.pop_front();
            if (rsp_if.slot !== exp.slot) begin
               $error("slot: expected %0d, actual %0d", exp.slot, rsp_if.slot);
               error_count++;
            end
            if (rsp_if.found !== exp.found) begin
               $error("found: expected %0b, actual %0b", exp.found, rsp_if.found);
               error_count++;
            end
            if (rsp_if.table_full !== exp.table_full) begin
               $error("table_full: expected %0b, actual %0b", exp.table_full,
                      rsp_if.table_full);
               error_count++;
            end
            if (rsp_if.descriptor_out !== exp.descriptor_out) begin
               $error("descriptor_out: expected %h, actual %h", exp.descriptor_out,
                      rsp_if.descriptor_out);
               error_count++;
            end
            if (rsp_if.send_handle_out !== exp.send_handle_out) begin
               $error("send_handle_out: expected %h, actual %h", exp.send_handle_out,
                      rsp_if.send_handle_out);
               error_count++;
            end
            if (rsp_if.done_handle_out !== exp.done_handle_out) begin
               $error("done_handle_out: expected %h, actual %h", exp.done_handle_out,
                      rsp_if.done_handle_out);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      error_count        = 0;
      idle_cycles        = 0;
      burst_left         = 0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.command     = CMD_INSERT;
      req_if.key         = '0;
      req_if.descriptor  = '0;
      req_if.send_handle = '0;
      req_if.done_handle = '0;
      foreach (endpoint_slots[i]) endpoint_slots[i] = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      test_key_zero();
      test_empty_misses();
      test_field_extremes();
      test_probe_collisions();
      test_fill_to_full();
      test_random_traffic(900);

      @(negedge clock);
      req_if.valid = 1'b0;
      while (slot_reports_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
